@@ rtl/clpt_pkg.sv @@
// Shared types and constants of the command line pipeline tokenizer.
// Used by clpt_front, clpt_queue, clpt_back and the top level; no dependencies.
package clpt_pkg;

    // Scanner modes, one-hot
    typedef enum logic [5:0] {
        M_BETWEEN = 6'b000001,
        M_WORD    = 6'b000010,
        M_QUOTED  = 6'b000100,
        M_QFULL   = 6'b001000,
        M_GT      = 6'b010000,
        M_DISCARD = 6'b100000
    } t_mode;

    // Token roles; the pending redirection uses the same codes, NONE sharing ARG's
    localparam logic [1:0] R_ARG    = 2'd0;
    localparam logic [1:0] R_IN     = 2'd1;
    localparam logic [1:0] R_OUT    = 2'd2;
    localparam logic [1:0] R_APPEND = 2'd3;
    localparam logic [1:0] P_NONE   = 2'd0;

    // Result event codes
    localparam logic [2:0] EV_ARGBYTE = 3'd0;
    localparam logic [2:0] EV_ARGEND  = 3'd1;
    localparam logic [2:0] EV_INBYTE  = 3'd2;
    localparam logic [2:0] EV_OUTBYTE = 3'd3;
    localparam logic [2:0] EV_NAMEEND = 3'd4;
    localparam logic [2:0] EV_PIPE    = 3'd5;
    localparam logic [2:0] EV_LINEEND = 3'd6;

    // Line status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EMPTY_PIPE = 3'd1;
    localparam logic [2:0] ST_MANY_CMDS  = 3'd2;
    localparam logic [2:0] ST_NO_NAME    = 3'd3;
    localparam logic [2:0] ST_MANY_ARGS  = 3'd4;
    localparam logic [2:0] ST_EMPTY_LAST = 3'd5;

    // Input action codes
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_LINEEND = 1'b1;

    // Special bytes
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_PIPE = 8'h7C;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // One result event
    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] ch;
        logic [2:0] cmd;
        logic [3:0] arg;
        logic       app;
        logic [2:0] st;
    } t_res;

    // All results of one input item
    typedef struct packed {
        logic [1:0]       cnt;
        t_res [2:0]       res;
    } t_bundle;

    // Front to queue write
    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_push;

endpackage

@@ rtl/clpt_front.sv @@
// Front part of the tokenizer: scanner state and classification of each byte.
// Turns one accepted item into a bundle of up to three result events; uses clpt_pkg.
module clpt_front #(
    parameter int MAX_TOKEN_LEN = 128,
    parameter int MAX_ARGS      = 16,
    parameter int MAX_COMMANDS  = 8,
    parameter int FILENAME_LEN  = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_ready,
    input  logic              i_action,
    input  logic [7:0]        i_char,
    output clpt_pkg::t_push   o_push
);

    localparam int LW = $clog2(MAX_TOKEN_LEN);
    localparam int CW = $clog2(MAX_COMMANDS + 1);
    localparam int AW = $clog2(MAX_ARGS + 1);

    clpt_pkg::t_mode r_mode, n_mode;
    logic            r_qd, n_qd;
    logic [LW-1:0]   r_len, n_len;
    logic [1:0]      r_role, n_role;
    logic [1:0]      r_pend, n_pend;
    logic [CW-1:0]   r_cmd, n_cmd;
    logic [AW-1:0]   r_arg, n_arg;
    logic [2:0]      r_err, n_err;

    clpt_pkg::t_res [2:0] res;
    logic [1:0]           cnt;
    logic                 do_between;
    logic                 limit;
    logic [7:0]           qch;
    logic [2:0]           st;
    logic                 accept;

    assign accept = i_valid & i_ready;

    function automatic clpt_pkg::t_res mk(input logic [2:0] ev, input logic [7:0] ch,
                                          input logic [2:0] cmd, input logic [3:0] arg,
                                          input logic app, input logic [2:0] lst);
        clpt_pkg::t_res r;
        r.ev  = ev;
        r.ch  = ch;
        r.cmd = cmd;
        r.arg = arg;
        r.app = app;
        r.st  = lst;
        return r;
    endfunction

    // Classify the item and work out the next scanner state
    always_comb begin
        n_mode     = r_mode;
        n_qd       = r_qd;
        n_len      = r_len;
        n_role     = r_role;
        n_pend     = r_pend;
        n_cmd      = r_cmd;
        n_arg      = r_arg;
        n_err      = r_err;
        res        = '0;
        cnt        = 2'd0;
        do_between = 1'b0;
        limit      = 1'b0;
        st         = clpt_pkg::ST_OK;
        qch        = r_qd ? clpt_pkg::CH_DQ : clpt_pkg::CH_SQ;

        if (i_action == clpt_pkg::ACT_LINEEND) begin
            // close an open token, then report the line
            if (r_mode == clpt_pkg::M_WORD || r_mode == clpt_pkg::M_QUOTED) begin
                if (r_role == clpt_pkg::R_ARG) begin
                    res[cnt] = mk(clpt_pkg::EV_ARGEND, 8'd0, 3'(32'(r_cmd) - 1),
                                  4'(32'(r_arg) - 1), 1'b0, clpt_pkg::ST_OK);
                end else begin
                    res[cnt] = mk(clpt_pkg::EV_NAMEEND, 8'd0, 3'(32'(r_cmd) - 1), 4'd0,
                                  r_role == clpt_pkg::R_APPEND, clpt_pkg::ST_OK);
                end
                cnt = cnt + 2'd1;
            end
            if (r_err != clpt_pkg::ST_OK) begin
                st = r_err;
            end else if (r_mode == clpt_pkg::M_GT || r_pend != clpt_pkg::P_NONE) begin
                st = clpt_pkg::ST_NO_NAME;
            end else if (r_arg == '0 && 32'(r_cmd) > 1) begin
                st = clpt_pkg::ST_EMPTY_LAST;
            end
            res[cnt] = mk(clpt_pkg::EV_LINEEND, 8'd0, 3'(32'(r_cmd) - 1), 4'd0, 1'b0, st);
            cnt      = cnt + 2'd1;
            n_mode   = clpt_pkg::M_BETWEEN;
            n_qd     = 1'b0;
            n_len    = '0;
            n_role   = clpt_pkg::R_ARG;
            n_pend   = clpt_pkg::P_NONE;
            n_cmd    = CW'(1);
            n_arg    = '0;
            n_err    = clpt_pkg::ST_OK;
        end else begin
            case (r_mode)
                clpt_pkg::M_BETWEEN: begin
                    do_between = 1'b1;
                end
                clpt_pkg::M_WORD, clpt_pkg::M_QUOTED: begin
                    if (r_mode == clpt_pkg::M_WORD && (i_char inside {clpt_pkg::CH_NUL,
                            clpt_pkg::CH_SP, clpt_pkg::CH_TAB, clpt_pkg::CH_PIPE,
                            clpt_pkg::CH_LT, clpt_pkg::CH_GT})) begin
                        // separator or operator ends the word
                        limit      = 1'b1;
                        n_mode     = clpt_pkg::M_BETWEEN;
                        do_between = 1'b1;
                    end else if (r_mode == clpt_pkg::M_QUOTED && i_char == qch) begin
                        limit  = 1'b1;
                        n_mode = clpt_pkg::M_BETWEEN;
                    end else if (r_mode == clpt_pkg::M_QUOTED && i_char == clpt_pkg::CH_NUL) begin
                        limit  = 1'b1;
                        n_mode = clpt_pkg::M_DISCARD;
                    end else begin
                        // token byte
                        if (r_role == clpt_pkg::R_ARG) begin
                            res[cnt] = mk(clpt_pkg::EV_ARGBYTE, i_char, 3'(32'(r_cmd) - 1),
                                          4'(32'(r_arg) - 1), 1'b0, clpt_pkg::ST_OK);
                            cnt = cnt + 2'd1;
                        end else if (32'(r_len) < 32'(FILENAME_LEN - 1)) begin
                            res[cnt] = mk((r_role == clpt_pkg::R_IN) ? clpt_pkg::EV_INBYTE :
                                          clpt_pkg::EV_OUTBYTE, i_char, 3'(32'(r_cmd) - 1),
                                          4'd0, 1'b0, clpt_pkg::ST_OK);
                            cnt = cnt + 2'd1;
                        end
                        n_len = r_len + LW'(1);
                        if (32'(n_len) >= 32'(MAX_TOKEN_LEN - 1)) begin
                            limit  = 1'b1;
                            n_mode = (r_mode == clpt_pkg::M_WORD) ? clpt_pkg::M_BETWEEN :
                                     clpt_pkg::M_QFULL;
                        end
                    end
                    // limit here flags a token end to report
                    if (limit) begin
                        if (r_role == clpt_pkg::R_ARG) begin
                            res[cnt] = mk(clpt_pkg::EV_ARGEND, 8'd0, 3'(32'(r_cmd) - 1),
                                          4'(32'(r_arg) - 1), 1'b0, clpt_pkg::ST_OK);
                        end else begin
                            res[cnt] = mk(clpt_pkg::EV_NAMEEND, 8'd0, 3'(32'(r_cmd) - 1),
                                          4'd0, r_role == clpt_pkg::R_APPEND,
                                          clpt_pkg::ST_OK);
                        end
                        cnt = cnt + 2'd1;
                    end
                end
                clpt_pkg::M_QFULL: begin
                    // a closing quote right after the limit is dropped
                    n_mode     = clpt_pkg::M_BETWEEN;
                    do_between = (i_char != qch);
                end
                clpt_pkg::M_GT: begin
                    n_mode = clpt_pkg::M_BETWEEN;
                    if (i_char == clpt_pkg::CH_GT) begin
                        n_pend = clpt_pkg::R_APPEND;
                    end else begin
                        n_pend     = clpt_pkg::R_OUT;
                        do_between = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // Scan a byte outside any token
            if (do_between) begin
                if (i_char inside {clpt_pkg::CH_SP, clpt_pkg::CH_TAB}) begin
                    n_mode = n_mode;
                end else if (i_char == clpt_pkg::CH_NUL) begin
                    n_mode = clpt_pkg::M_DISCARD;
                end else if (i_char inside {clpt_pkg::CH_PIPE, clpt_pkg::CH_LT,
                                            clpt_pkg::CH_GT}) begin
                    if (n_pend != clpt_pkg::P_NONE) begin
                        n_err  = clpt_pkg::ST_NO_NAME;
                        n_mode = clpt_pkg::M_DISCARD;
                    end else if (i_char == clpt_pkg::CH_PIPE) begin
                        if (n_arg == '0) begin
                            n_err  = clpt_pkg::ST_EMPTY_PIPE;
                            n_mode = clpt_pkg::M_DISCARD;
                        end else if (32'(n_cmd) >= 32'(MAX_COMMANDS)) begin
                            n_err  = clpt_pkg::ST_MANY_CMDS;
                            n_mode = clpt_pkg::M_DISCARD;
                        end else begin
                            n_cmd    = n_cmd + CW'(1);
                            n_arg    = '0;
                            res[cnt] = mk(clpt_pkg::EV_PIPE, 8'd0, 3'(32'(n_cmd) - 1), 4'd0,
                                          1'b0, clpt_pkg::ST_OK);
                            cnt      = cnt + 2'd1;
                        end
                    end else if (i_char == clpt_pkg::CH_LT) begin
                        n_pend = clpt_pkg::R_IN;
                    end else begin
                        n_mode = clpt_pkg::M_GT;
                    end
                end else if (n_pend == clpt_pkg::P_NONE && 32'(n_arg) >= 32'(MAX_ARGS)) begin
                    n_err  = clpt_pkg::ST_MANY_ARGS;
                    n_mode = clpt_pkg::M_DISCARD;
                end else begin
                    // start a token
                    if (n_pend == clpt_pkg::P_NONE) begin
                        n_arg  = n_arg + AW'(1);
                        n_role = clpt_pkg::R_ARG;
                    end else begin
                        n_role = n_pend;
                        n_pend = clpt_pkg::P_NONE;
                    end
                    n_len = '0;
                    if (i_char inside {clpt_pkg::CH_SQ, clpt_pkg::CH_DQ}) begin
                        n_qd   = (i_char == clpt_pkg::CH_DQ);
                        n_mode = clpt_pkg::M_QUOTED;
                    end else begin
                        n_mode = clpt_pkg::M_WORD;
                        if (n_role == clpt_pkg::R_ARG) begin
                            res[cnt] = mk(clpt_pkg::EV_ARGBYTE, i_char, 3'(32'(n_cmd) - 1),
                                          4'(32'(n_arg) - 1), 1'b0, clpt_pkg::ST_OK);
                        end else begin
                            res[cnt] = mk((n_role == clpt_pkg::R_IN) ? clpt_pkg::EV_INBYTE :
                                          clpt_pkg::EV_OUTBYTE, i_char, 3'(32'(n_cmd) - 1),
                                          4'd0, 1'b0, clpt_pkg::ST_OK);
                        end
                        cnt   = cnt + 2'd1;
                        n_len = LW'(1);
                        if (1 >= MAX_TOKEN_LEN - 1) begin
                            if (n_role == clpt_pkg::R_ARG) begin
                                res[cnt] = mk(clpt_pkg::EV_ARGEND, 8'd0, 3'(32'(n_cmd) - 1),
                                              4'(32'(n_arg) - 1), 1'b0, clpt_pkg::ST_OK);
                            end else begin
                                res[cnt] = mk(clpt_pkg::EV_NAMEEND, 8'd0,
                                              3'(32'(n_cmd) - 1), 4'd0,
                                              n_role == clpt_pkg::R_APPEND,
                                              clpt_pkg::ST_OK);
                            end
                            cnt    = cnt + 2'd1;
                            n_mode = clpt_pkg::M_BETWEEN;
                        end
                    end
                end
            end
        end
    end

    // Hand the bundle to the queue when the item produced results
    always_comb begin
        o_push.valid      = accept && (cnt != 2'd0);
        o_push.bundle.cnt = cnt;
        o_push.bundle.res = res;
    end

    // Advance scanner state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= clpt_pkg::M_BETWEEN;
            r_qd   <= 1'b0;
            r_len  <= '0;
            r_role <= clpt_pkg::R_ARG;
            r_pend <= clpt_pkg::P_NONE;
            r_cmd  <= CW'(1);
            r_arg  <= '0;
            r_err  <= clpt_pkg::ST_OK;
        end else if (accept) begin
            r_mode <= n_mode;
            r_qd   <= n_qd;
            r_len  <= n_len;
            r_role <= n_role;
            r_pend <= n_pend;
            r_cmd  <= n_cmd;
            r_arg  <= n_arg;
            r_err  <= n_err;
        end
    end

endmodule

@@ rtl/clpt_queue.sv @@
// Short queue of result bundles between the tokenizer front and back.
// Register based ring buffer; uses clpt_pkg for the bundle type and depth.
module clpt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clpt_pkg::t_push   i_push,
    output logic              o_full,
    output logic              o_valid,
    output clpt_pkg::t_bundle o_data,
    input  logic              i_pop
);

    clpt_pkg::t_bundle r_mem [clpt_pkg::QDEPTH];
    logic [clpt_pkg::QAW-1:0] r_wr, r_rd;
    logic [clpt_pkg::QAW:0]   r_cnt;
    logic                     push, pop;

    assign o_full  = (r_cnt == (clpt_pkg::QAW + 1)'(clpt_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_push.valid && !o_full;
    assign pop     = i_pop && o_valid;

    // Store pushed bundles
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.bundle;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + clpt_pkg::QAW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + clpt_pkg::QAW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + (clpt_pkg::QAW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (clpt_pkg::QAW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/clpt_back.sv @@
// Back part of the tokenizer: unpacks queued bundles into single result beats.
// Drives the output stream and marks the final beat of each item; uses clpt_pkg.
module clpt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  clpt_pkg::t_bundle i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output clpt_pkg::t_res    o_res,
    output logic              o_last
);

    clpt_pkg::t_bundle r_bundle;
    logic              r_busy;
    logic [1:0]        r_idx;
    logic              done;

    assign o_valid = r_busy;
    assign o_res   = r_bundle.res[r_idx];
    assign o_last  = (r_idx == r_bundle.cnt - 2'd1);
    assign done    = r_busy && i_ready && o_last;
    assign o_q_pop = i_q_valid && (!r_busy || done);

    // Load the next bundle; hold the current one while stalled
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bundle <= i_q_data;
        end
    end

    // Step through the results of the current bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

@@ rtl/command_line_pipeline_tokenizer.sv @@
// Command line pipeline tokenizer, top level.
// Connects clpt_front, clpt_queue and clpt_back; uses clpt_pkg.
//
// Usage:
//   Input stream: one beat per line byte (tuser = 0, byte in tdata) or one
//   beat for the end of the line (tuser = 1). Output stream: one beat per
//   event (argument/filename byte, token end, pipe, line end), event code in
//   tuser, tlast on the final event caused by one input beat.
//   Throughput: one input beat per cycle while the bundle queue is not full.
//   Items that cause no event are not queued; an item with n events gives n
//   output beats. Each event is registered in the bundle queue and then in
//   the output stage before it can be taken at the output.
//   A four-entry bundle queue between the scanner and the output stage lets
//   the input keep flowing while the receiver stalls; tready drops only when
//   that queue is full. Stalled output beats hold their value.
//   Reset (synchronous, active low) returns the scanner to the start of a
//   line and empties the queue and the output stage.
//   Errors are reported once, in the line end status; bytes after an error
//   are dropped until the end of the line.
module command_line_pipeline_tokenizer #(
    parameter int MAX_TOKEN_LEN = 128,
    parameter int MAX_ARGS      = 16,
    parameter int MAX_COMMANDS  = 8,
    parameter int FILENAME_LEN  = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_in
    input  logic        i_s_axis_tuser,   // [0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] char_out, [10:8] command_index,
                                          // [14:11] arg_index, [15] append_mode,
                                          // [18:16] line_status, [23:19] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] event_res
    output logic        o_m_axis_tlast    // last event of the input beat
);

    clpt_pkg::t_push   push;
    clpt_pkg::t_bundle q_data;
    clpt_pkg::t_res    res;
    logic              q_full, q_valid, q_pop;

    assign o_s_axis_tready = !q_full;

    clpt_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .MAX_ARGS      (MAX_ARGS),
        .MAX_COMMANDS  (MAX_COMMANDS),
        .FILENAME_LEN  (FILENAME_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_ready  (o_s_axis_tready),
        .i_action (i_s_axis_tuser),
        .i_char   (i_s_axis_tdata),
        .o_push   (push)
    );

    clpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    clpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (res),
        .o_last    (o_m_axis_tlast)
    );

    // Pack the output beat
    assign o_m_axis_tuser = res.ev;
    assign o_m_axis_tdata = {5'd0, res.st, res.app, res.arg, res.cmd, res.ch};

`ifndef SYNTHESIS
    // A line end is always the final event of its input beat
    a_lineend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == clpt_pkg::EV_LINEEND) |-> o_m_axis_tlast)
        else $error("line end event without tlast");

    // Only a line end carries a status
    a_status_lineend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != clpt_pkg::EV_LINEEND)
            |-> (o_m_axis_tdata[18:16] == clpt_pkg::ST_OK))
        else $error("status on an event other than line end");

    // Reset empties the output stage
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
